@@ sv/uets_pkg.sv @@
package uets_pkg;

    localparam int LEN_W            = 16;
    localparam int ARM_W            = 11;
    localparam int UNITS_W          = 5;
    localparam int UNIT_SHIFT       = 6;
    localparam int MAX_PACKET_UNITS = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DONE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_IN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_UNITS = 1'd1;

    typedef struct packed {
        logic             operation;
        logic [LEN_W-1:0] transfer_length;
        logic [ARM_W-1:0] received_length;
    } t_item;

    typedef struct packed {
        logic             arm_valid;
        logic [ARM_W-1:0] arm_length;
        logic             arm_pid;
        logic             arm_full;
        logic [LEN_W-1:0] copy_offset;
        logic [ARM_W-1:0] copy_length;
        logic             done_res;
        logic [LEN_W-1:0] done_length;
        logic             error;
    } t_result;

    function automatic logic [ARM_W-1:0] f_packet_bytes(input logic [UNITS_W-1:0] units);
        logic [UNITS_W-1:0] u;
        begin
            u = units;
            if (u == '0) begin
                u = UNITS_W'(1);
            end
            if (u > UNITS_W'(MAX_PACKET_UNITS)) begin
                u = UNITS_W'(MAX_PACKET_UNITS);
            end
            f_packet_bytes = ARM_W'({u, {UNIT_SHIFT{1'b0}}});
        end
    endfunction

    function automatic logic [ARM_W-1:0] f_chunk(input logic [LEN_W-1:0] left,
                                                 input logic [ARM_W-1:0] mps);
        begin
            if (left > LEN_W'(mps)) begin
                f_chunk = mps;
            end else begin
                f_chunk = ARM_W'(left);
            end
        end
    endfunction

endpackage

@@ sv/uets_in_stage.sv @@
module uets_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  uets_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output uets_pkg::t_item o_item
);

    logic            r_valid;
    uets_pkg::t_item r_item;
    logic            n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ sv/uets_seq.sv @@
module uets_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [uets_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uets_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_take,
    input  uets_pkg::t_item                     i_item,
    output uets_pkg::t_result                   o_result
);

    logic                              r_direction_in;
    logic [uets_pkg::UNITS_W-1:0]      r_units;
    logic                              r_active;
    logic [uets_pkg::LEN_W-1:0]        r_remaining;
    logic [uets_pkg::LEN_W-1:0]        r_total;
    logic [uets_pkg::LEN_W-1:0]        r_offset;
    logic [uets_pkg::ARM_W-1:0]        r_armed;
    logic                              r_toggle;

    logic                              n_active;
    logic [uets_pkg::LEN_W-1:0]        n_remaining;
    logic [uets_pkg::LEN_W-1:0]        n_total;
    logic [uets_pkg::LEN_W-1:0]        n_offset;
    logic [uets_pkg::ARM_W-1:0]        n_armed;
    logic                              n_toggle;

    logic [uets_pkg::ARM_W-1:0]        mps;
    logic [uets_pkg::ARM_W-1:0]        cur;
    logic [uets_pkg::ARM_W-1:0]        rx;
    logic                              do_arm;
    uets_pkg::t_result                 res;

    assign mps = uets_pkg::f_packet_bytes(r_units);

    always_comb begin
        res         = '0;
        n_active    = r_active;
        n_remaining = r_remaining;
        n_total     = r_total;
        n_offset    = r_offset;
        n_armed     = r_armed;
        n_toggle    = r_toggle;
        cur         = '0;
        rx          = '0;
        do_arm      = 1'b0;
        if (i_item.operation == uets_pkg::OP_START) begin
            cur         = uets_pkg::f_chunk(i_item.transfer_length, mps);
            n_active    = 1'b1;
            n_total     = i_item.transfer_length;
            n_remaining = i_item.transfer_length;
            n_offset    = '0;
            if (r_direction_in && (cur != '0)) begin
                res.copy_length = cur;
                n_remaining     = i_item.transfer_length - uets_pkg::LEN_W'(cur);
                n_offset        = uets_pkg::LEN_W'(cur);
            end
            do_arm = 1'b1;
        end else if (!r_active) begin
            res.error = 1'b1;
        end else if (r_direction_in) begin
            if (r_remaining == '0) begin
                n_active        = 1'b0;
                res.done_res    = 1'b1;
                res.done_length = r_total;
            end else begin
                cur             = uets_pkg::f_chunk(r_remaining, mps);
                res.copy_offset = r_offset;
                res.copy_length = cur;
                n_remaining     = r_remaining - uets_pkg::LEN_W'(cur);
                n_offset        = r_offset + uets_pkg::LEN_W'(cur);
                do_arm          = 1'b1;
            end
        end else begin
            rx = i_item.received_length;
            if (rx > r_armed) begin
                rx = r_armed;
            end
            if (uets_pkg::LEN_W'(rx) > r_remaining) begin
                rx = r_remaining[uets_pkg::ARM_W-1:0];
            end
            if (rx != '0) begin
                res.copy_offset = r_offset;
                res.copy_length = rx;
            end
            n_remaining = r_remaining - uets_pkg::LEN_W'(rx);
            n_offset    = r_offset + uets_pkg::LEN_W'(rx);
            if ((n_remaining == '0) || (rx < r_armed)) begin
                n_active        = 1'b0;
                res.done_res    = 1'b1;
                res.done_length = r_total - n_remaining;
            end else begin
                cur    = uets_pkg::f_chunk(n_remaining, mps);
                do_arm = 1'b1;
            end
        end
        if (do_arm) begin
            n_armed        = cur;
            res.arm_valid  = 1'b1;
            res.arm_length = cur;
            res.arm_pid    = r_toggle;
            res.arm_full   = r_direction_in;
            n_toggle       = !r_toggle;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction_in <= 1'b1;
            r_units        <= uets_pkg::UNITS_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                uets_pkg::REG_DIRECTION_IN: begin
                    r_direction_in <= i_cfg_wdata[0];
                end
                uets_pkg::REG_MAX_PACKET_UNITS: begin
                    r_units <= i_cfg_wdata[uets_pkg::UNITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_remaining <= '0;
            r_total     <= '0;
            r_offset    <= '0;
            r_armed     <= '0;
            r_toggle    <= 1'b0;
        end else if (i_take) begin
            r_active    <= n_active;
            r_remaining <= n_remaining;
            r_total     <= n_total;
            r_offset    <= n_offset;
            r_armed     <= n_armed;
            r_toggle    <= n_toggle;
        end
    end

endmodule

@@ sv/uets_out_stage.sv @@
module uets_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  uets_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output uets_pkg::t_result o_result
);

    logic              r_valid;
    uets_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ sv/usb_endpoint_transfer_sequencer_top.sv @@
// usb endpoint transfer sequencer
// input channel: i_in_valid / o_in_ready with operation, transfer_length and
//   received_length; a start item arms the first packet, a buffer done item
//   advances the running transfer
// output channel: o_out_valid / i_out_ready, exactly one result item per input
//   item, in order
// config: i_cfg_wr_en with i_cfg_index (0 direction_in, 1 max_packet_units)
//   and i_cfg_wdata, taken at once; write only while no item is in flight
// latency: result valid 1 cycle after input accept (input register, then
//   result register loaded at the next edge); throughput 1 item per cycle, set
//   by the single compare-subtract step between the two registers
// stall: a held result keeps the output register; the input register still
//   takes one more item, then o_in_ready drops until the result is taken
// reset: synchronous active low; clears both valid flags, the transfer state
//   and the data toggle (DATA0), sets direction_in to 1 and max_packet_units
//   to 1
module usb_endpoint_transfer_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [uets_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uets_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [uets_pkg::LEN_W-1:0]          i_transfer_length,
    input  logic [uets_pkg::ARM_W-1:0]          i_received_length,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_arm_valid,
    output logic [uets_pkg::ARM_W-1:0]          o_arm_length,
    output logic                                o_arm_pid,
    output logic                                o_arm_full,
    output logic [uets_pkg::LEN_W-1:0]          o_copy_offset,
    output logic [uets_pkg::ARM_W-1:0]          o_copy_length,
    output logic                                o_done_res,
    output logic [uets_pkg::LEN_W-1:0]          o_done_length,
    output logic                                o_error
);

    uets_pkg::t_item   in_item;
    uets_pkg::t_item   held_item;
    uets_pkg::t_result seq_result;
    uets_pkg::t_result out_result;
    logic              held_valid;
    logic              can_load;
    logic              take;

    assign in_item.operation       = i_operation;
    assign in_item.transfer_length = i_transfer_length;
    assign in_item.received_length = i_received_length;

    assign take = held_valid && can_load;

    uets_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    uets_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_item      (held_item),
        .o_result    (seq_result)
    );

    uets_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_result   (seq_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_arm_valid   = out_result.arm_valid;
    assign o_arm_length  = out_result.arm_length;
    assign o_arm_pid     = out_result.arm_pid;
    assign o_arm_full    = out_result.arm_full;
    assign o_copy_offset = out_result.copy_offset;
    assign o_copy_length = out_result.copy_length;
    assign o_done_res    = out_result.done_res;
    assign o_done_length = out_result.done_length;
    assign o_error       = out_result.error;

endmodule

@@ verif/usb_endpoint_transfer_sequencer_checker.sv @@
`timescale 1ns / 100ps

module usb_endpoint_transfer_sequencer_checker
    import uets_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_operation,
    input  logic [LEN_W-1:0]     i_transfer_length,
    input  logic [ARM_W-1:0]     i_received_length,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_arm_valid,
    input  logic [ARM_W-1:0]     i_arm_length,
    input  logic                 i_arm_pid,
    input  logic                 i_arm_full,
    input  logic [LEN_W-1:0]     i_copy_offset,
    input  logic [ARM_W-1:0]     i_copy_length,
    input  logic                 i_done_res,
    input  logic [LEN_W-1:0]     i_done_length,
    input  logic                 i_error,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    logic               dir_in;
    logic [UNITS_W-1:0] mps_units;
    logic               xfer_active;
    logic [LEN_W-1:0]   left_bytes;
    logic [LEN_W-1:0]   total_bytes;
    logic [LEN_W-1:0]   user_offset;
    logic [ARM_W-1:0]   armed_len;
    logic               data_toggle;

    t_result transfer_results[$];
    int      fail_count;
    int      checked;

    function automatic logic [ARM_W-1:0] packet_limit(input logic [UNITS_W-1:0] units);
        logic [UNITS_W-1:0] u;
        u = units;
        if (u == '0) begin
            u = UNITS_W'(1);
        end else if (u > UNITS_W'(MAX_PACKET_UNITS)) begin
            u = UNITS_W'(MAX_PACKET_UNITS);
        end
        return ARM_W'(u) << UNIT_SHIFT;
    endfunction

    function automatic logic [ARM_W-1:0] chunk_of(input logic [LEN_W-1:0] left,
                                                  input logic [ARM_W-1:0] mps);
        return (left > LEN_W'(mps)) ? mps : ARM_W'(left);
    endfunction

    task automatic arm_packet(inout t_result r, input logic [ARM_W-1:0] len);
        armed_len   = len;
        r.arm_valid  = 1'b1;
        r.arm_length = len;
        r.arm_pid    = data_toggle;
        r.arm_full   = dir_in;
        data_toggle = ~data_toggle;
    endtask

    task automatic predict_packet(input logic op, input logic [LEN_W-1:0] xlen,
                                  input logic [ARM_W-1:0] rxlen, output t_result r);
        logic [ARM_W-1:0] mps;
        logic [ARM_W-1:0] chunk;
        logic [ARM_W-1:0] rx;
        r = '0;
        mps = packet_limit(mps_units);
        if (op == OP_START) begin
            chunk = chunk_of(xlen, mps);
            xfer_active = 1'b1;
            total_bytes = xlen;
            left_bytes  = xlen;
            user_offset = '0;
            if (dir_in && chunk != '0) begin
                r.copy_length = chunk;
                left_bytes    = left_bytes - LEN_W'(chunk);
                user_offset   = LEN_W'(chunk);
            end
            arm_packet(r, chunk);
        end else if (!xfer_active) begin
            r.error = 1'b1;
        end else if (dir_in) begin
            if (left_bytes == '0) begin
                xfer_active   = 1'b0;
                r.done_res    = 1'b1;
                r.done_length = total_bytes;
            end else begin
                chunk = chunk_of(left_bytes, mps);
                r.copy_offset = user_offset;
                r.copy_length = chunk;
                left_bytes    = left_bytes - LEN_W'(chunk);
                user_offset   = user_offset + LEN_W'(chunk);
                arm_packet(r, chunk);
            end
        end else begin
            rx = rxlen;
            if (rx > armed_len) begin
                rx = armed_len;
            end
            if (LEN_W'(rx) > left_bytes) begin
                rx = ARM_W'(left_bytes);
            end
            if (rx != '0) begin
                r.copy_offset = user_offset;
                r.copy_length = rx;
            end
            left_bytes  = left_bytes - LEN_W'(rx);
            user_offset = user_offset + LEN_W'(rx);
            // short packet or nothing left ends the transfer
            if (left_bytes == '0 || rx < armed_len) begin
                xfer_active   = 1'b0;
                r.done_res    = 1'b1;
                r.done_length = total_bytes - left_bytes;
            end else begin
                arm_packet(r, chunk_of(left_bytes, mps));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            dir_in      = 1'b1;
            mps_units   = UNITS_W'(1);
            xfer_active = 1'b0;
            left_bytes  = '0;
            total_bytes = '0;
            user_offset = '0;
            armed_len   = '0;
            data_toggle = 1'b0;
            transfer_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_DIRECTION_IN: begin
                        dir_in = i_cfg_wdata[0];
                    end
                    REG_MAX_PACKET_UNITS: begin
                        mps_units = i_cfg_wdata[UNITS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_packet(i_operation, i_transfer_length, i_received_length, want);
                transfer_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (transfer_results.size() == 0) begin
                    $error("result item with no expected result waiting");
                    fail_count++;
                end else begin
                    want = transfer_results.pop_front();
                    check_field("arm_valid", LEN_W'(want.arm_valid), LEN_W'(i_arm_valid));
                    check_field("arm_length", LEN_W'(want.arm_length), LEN_W'(i_arm_length));
                    check_field("arm_pid", LEN_W'(want.arm_pid), LEN_W'(i_arm_pid));
                    check_field("arm_full", LEN_W'(want.arm_full), LEN_W'(i_arm_full));
                    check_field("copy_offset", want.copy_offset, i_copy_offset);
                    check_field("copy_length", LEN_W'(want.copy_length),
                                LEN_W'(i_copy_length));
                    check_field("done_res", LEN_W'(want.done_res), LEN_W'(i_done_res));
                    check_field("done_length", want.done_length, i_done_length);
                    check_field("error", LEN_W'(want.error), LEN_W'(i_error));
                    checked++;
                end
            end
        end
        o_pending    <= transfer_results.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

@@ verif/tb_usb_endpoint_transfer_sequencer_top.sv @@
`timescale 1ns / 100ps

module tb_usb_endpoint_transfer_sequencer_top;
    import uets_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  operation = OP_START;
    logic [LEN_W-1:0]      transfer_length = '0;
    logic [ARM_W-1:0]      received_length = '0;
    logic                  out_ready = 1'b0;

    logic             in_ready;
    logic             out_valid;
    logic             arm_valid;
    logic [ARM_W-1:0] arm_length;
    logic             arm_pid;
    logic             arm_full;
    logic [LEN_W-1:0] copy_offset;
    logic [ARM_W-1:0] copy_length;
    logic             done_res;
    logic [LEN_W-1:0] done_length;
    logic             error;

    int fail_count;
    int pending;
    int checked;

    logic               cur_dir = 1'b1;
    logic [UNITS_W-1:0] cur_units = UNITS_W'(1);
    bit                 no_idle = 1'b0;
    int                 items_sent = 0;
    int                 start_count = 0;
    int                 done_count = 0;
    int                 reg_writes = 0;
    int                 cycles = 0;

    usb_endpoint_transfer_sequencer_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_operation       (operation),
        .i_transfer_length (transfer_length),
        .i_received_length (received_length),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_arm_valid       (arm_valid),
        .o_arm_length      (arm_length),
        .o_arm_pid         (arm_pid),
        .o_arm_full        (arm_full),
        .o_copy_offset     (copy_offset),
        .o_copy_length     (copy_length),
        .o_done_res        (done_res),
        .o_done_length     (done_length),
        .o_error           (error)
    );

    usb_endpoint_transfer_sequencer_checker u_seq_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_operation       (operation),
        .i_transfer_length (transfer_length),
        .i_received_length (received_length),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_arm_valid       (arm_valid),
        .i_arm_length      (arm_length),
        .i_arm_pid         (arm_pid),
        .i_arm_full        (arm_full),
        .i_copy_offset     (copy_offset),
        .i_copy_length     (copy_length),
        .i_done_res        (done_res),
        .i_done_length     (done_length),
        .i_error           (error),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    function automatic int max_packet_bytes(input logic [UNITS_W-1:0] units);
        int u;
        u = units;
        if (u == 0) begin
            u = 1;
        end else if (u > MAX_PACKET_UNITS) begin
            u = MAX_PACKET_UNITS;
        end
        return u * 64;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int mps;
        int r;
        mps = max_packet_bytes(cur_units);
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return LEN_W'($urandom_range(0, 3 * mps));
        end
        if (r < 75) begin
            return LEN_W'(mps * $urandom_range(0, 4));
        end
        if (r < 94) begin
            return LEN_W'($urandom_range(0, 3000));
        end
        if (r < 99 || mps < 512) begin
            return LEN_W'($urandom_range(0, 5 * mps));
        end
        return LEN_W'($urandom_range(30000, 65535));
    endfunction

    task automatic send_item(input logic op, input logic [LEN_W-1:0] len,
                             input logic [ARM_W-1:0] rx);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        transfer_length <= len;
        received_length <= rx;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
        if (op == OP_START) begin
            start_count++;
        end else begin
            done_count++;
        end
    endtask

    // hold the sender until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        reg_writes++;
        if (idx == REG_DIRECTION_IN) begin
            cur_dir = val[0];
        end else begin
            cur_units = val[UNITS_W-1:0];
        end
    endtask

    task automatic run_transfer(input logic [LEN_W-1:0] len);
        int mps;
        int left;
        int armed;
        int rx;
        int taken;
        int r;
        bit open;
        mps = max_packet_bytes(cur_units);
        send_item(OP_START, len, ARM_W'($urandom_range(0, 1024)));
        left = len;
        armed = (left > mps) ? mps : left;
        if (cur_dir) begin
            left -= armed;
        end
        open = 1'b1;
        while (open) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                // abandoned, the next start drops it
                open = 1'b0;
            end else begin
                if (r < 6) begin
                    settle();
                    write_reg(REG_DIRECTION_IN, cur_dir ? CFG_DATA_W'(0) : CFG_DATA_W'(1));
                end
                if (cur_dir) begin
                    if (left == 0) begin
                        open = 1'b0;
                    end else begin
                        armed = (left > mps) ? mps : left;
                        left -= armed;
                    end
                    send_item(OP_DONE, LEN_W'($urandom), ARM_W'($urandom_range(0, 1024)));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        rx = armed;
                    end else if (r < 82 && armed > 0) begin
                        rx = $urandom_range(0, armed - 1);
                    end else begin
                        rx = $urandom_range(armed, 1024);
                    end
                    taken = (rx < armed) ? rx : armed;
                    if (taken > left) begin
                        taken = left;
                    end
                    left -= taken;
                    if (left == 0 || taken < armed) begin
                        open = 1'b0;
                    end else begin
                        armed = (left > mps) ? mps : left;
                    end
                    send_item(OP_DONE, LEN_W'($urandom), ARM_W'(rx));
                end
            end
        end
    endtask

    initial begin
        int phase;
        int n;
        int r;
        int target;
        logic [CFG_DATA_W-1:0] units;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // in, 64 byte packets
        send_item(OP_DONE, 16'hffff, 11'd1024);
        send_item(OP_START, 16'd0, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_START, 16'hffff, 11'd0);
        send_item(OP_START, 16'd100, 11'd1024);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);

        settle();
        write_reg(REG_MAX_PACKET_UNITS, CFG_DATA_W'(16));
        write_reg(REG_DIRECTION_IN, CFG_DATA_W'(0));
        send_item(OP_START, 16'hffff, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd1024);
        send_item(OP_DONE, 16'd0, 11'd1024);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_START, 16'd100, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd1024);
        send_item(OP_START, 16'd200, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd50);

        // direction flips with a transfer running
        send_item(OP_START, 16'd3000, 11'd0);
        settle();
        write_reg(REG_DIRECTION_IN, CFG_DATA_W'(1));
        send_item(OP_DONE, 16'd0, 11'd0);

        settle();
        write_reg(REG_MAX_PACKET_UNITS, CFG_DATA_W'(0));
        send_item(OP_START, 16'd130, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);

        settle();
        write_reg(REG_MAX_PACKET_UNITS, CFG_DATA_W'(31));
        send_item(OP_START, 16'd1024, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);
        send_item(OP_DONE, 16'd0, 11'd0);

        target = items_sent + RANDOM_ITEMS;
        for (phase = 0; items_sent < target; phase++) begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                units = CFG_DATA_W'($urandom_range(1, 16));
            end else if (r < 80) begin
                units = CFG_DATA_W'(1);
            end else if (r < 90) begin
                units = CFG_DATA_W'(16);
            end else if (r < 95) begin
                units = CFG_DATA_W'(0);
            end else begin
                units = CFG_DATA_W'($urandom_range(17, 31));
            end
            write_reg(REG_MAX_PACKET_UNITS, units);
            write_reg(REG_DIRECTION_IN, CFG_DATA_W'($urandom_range(0, 1)));
            no_idle <= (phase == 3);
            n = (phase == 3) ? 40 : $urandom_range(4, 16);
            for (int k = 0; k < n && items_sent < target; k++) begin
                if ($urandom_range(0, 99) < 6) begin
                    // stray buffer done
                    send_item(OP_DONE, LEN_W'($urandom), ARM_W'($urandom_range(0, 1024)));
                end else begin
                    run_transfer(pick_length());
                end
            end
        end

        settle();
        repeat (10) @(negedge clk);
        $display("covered %0d items (%0d starts, %0d buffer done) across %0d register writes",
                 items_sent, start_count, done_count, reg_writes);
        $display("%0d result items compared, both directions, packet sizes 64 to 1024",
                 checked);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
